>>> design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk_sig, rst_sig, prop)
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond)
`endif

`endif

>>> design/sobel_pkg.sv
package sobel_pkg;

    localparam int DEF_MAX_LINE_PIXELS = 1024;

    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 12;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 12'd480;

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_ENERGY,
        ST_ROOT,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic calc;
        logic energy;
        logic root_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic has_result;
        logic root_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> design/sobel_ctrl.sv
module sobel_ctrl
    import sobel_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  dp_stat_t    stat,
    output ctrl_cmd_t   cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = stat.has_result ? ST_ENERGY : ST_IDLE;
            end
            ST_ENERGY:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (stat.root_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_CALC:
            begin
                cmd.calc = 1'b1;
            end
            ST_ENERGY:
            begin
                cmd.energy = 1'b1;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
            end
            ST_OUT:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/sobel_dp.sv
module sobel_dp
    import sobel_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = DEF_MAX_LINE_PIXELS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_stat_t               stat,
    input  logic [WIDTH_BITS-1:0]  image_width,
    input  logic [HEIGHT_BITS-1:0] image_height,
    input  logic [7:0]             pixel,
    output logic [7:0]             magnitude,
    output logic                   last_of_frame,
    output logic                   out_valid,
    input  logic                   out_ready
);

    localparam int CW = (MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1;
    localparam logic [CW-1:0] LAST_ADDR = CW'(MAX_LINE_PIXELS - 1);

    // each word holds {two rows back, one row back}
    logic [15:0] line_mem [0:MAX_LINE_PIXELS-1];
    logic [15:0] rd_data_reg;

    logic [CW-1:0]          clear_addr_reg;
    logic [CW-1:0]          col_reg;
    logic [HEIGHT_BITS-1:0] row_reg;
    logic [7:0]             pixel_reg;
    logic [7:0]             win_reg [0:2][0:2];
    logic [7:0]             win_next [0:2][0:2];
    logic signed [10:0]     gx_reg;
    logic signed [10:0]     gy_reg;
    logic signed [10:0]     gx_next;
    logic signed [10:0]     gy_next;
    logic signed [21:0]     gx_wide;
    logic signed [21:0]     gy_wide;
    logic                   last_reg;
    logic [20:0]            energy_reg;
    logic [7:0]             root_reg;
    logic [7:0]             bit_reg;
    logic [7:0]             mag_reg;
    logic                   last_out_reg;
    logic                   out_valid_reg;

    logic [31:0] eff_w;
    logic [31:0] eff_h;
    logic [31:0] col32;
    logic [31:0] row32;
    logic        pos_valid;
    logic        pos_last;
    logic [7:0]  try_root;
    logic [15:0] try_sq;

    always_comb
    begin
        if (image_width < 11'd3)
        begin
            eff_w = 32'd3;
        end
        else if (32'(image_width) > 32'(MAX_LINE_PIXELS))
        begin
            eff_w = 32'(MAX_LINE_PIXELS);
        end
        else
        begin
            eff_w = 32'(image_width);
        end
        eff_h = (image_height < 12'd3) ? 32'd3 : 32'(image_height);
    end

    assign col32     = 32'(col_reg);
    assign row32     = 32'(row_reg);
    assign pos_valid = (row32 >= 32'd2) && (col32 >= 32'd2);
    assign pos_last  = (row32 == eff_h - 32'd1) && (col32 == eff_w - 32'd1);

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            line_mem[clear_addr_reg] <= '0;
        end
        else if (cmd.calc)
        begin
            line_mem[col_reg] <= {rd_data_reg[7:0], pixel_reg};
        end
        rd_data_reg <= line_mem[col_reg];
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = rd_data_reg[15:8];
        win_next[1][2] = rd_data_reg[7:0];
        win_next[2][2] = pixel_reg;
        gx_next = (11'(win_next[0][2]) + (11'(win_next[1][2]) << 1) + 11'(win_next[2][2]))
                - (11'(win_next[0][0]) + (11'(win_next[1][0]) << 1) + 11'(win_next[2][0]));
        gy_next = (11'(win_next[2][0]) + (11'(win_next[2][1]) << 1) + 11'(win_next[2][2]))
                - (11'(win_next[0][0]) + (11'(win_next[0][1]) << 1) + 11'(win_next[0][2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                clear_addr_reg <= clear_addr_reg + CW'(1);
            end
            if (cmd.calc)
            begin
                win_reg <= win_next;
                if (col32 + 32'd1 >= eff_w)
                begin
                    col_reg <= '0;
                    row_reg <= (row32 + 32'd1 >= eff_h) ? '0 : row_reg + HEIGHT_BITS'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign try_root = root_reg | bit_reg;
    assign try_sq   = 16'(try_root) * 16'(try_root);

    // sign-extended so the squares keep all their bits
    assign gx_wide = 22'(gx_reg);
    assign gy_wide = 22'(gy_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pixel_reg <= pixel;
        end
        if (cmd.calc)
        begin
            gx_reg   <= gx_next;
            gy_reg   <= gy_next;
            last_reg <= pos_last;
        end
        if (cmd.energy)
        begin
            energy_reg <= 21'(gx_wide * gx_wide) + 21'(gy_wide * gy_wide);
            root_reg   <= '0;
            bit_reg    <= 8'h80;
        end
        if (cmd.root_step)
        begin
            // one result bit per cycle, msb first
            if (try_sq <= energy_reg[15:0])
            begin
                root_reg <= try_root;
            end
            bit_reg <= bit_reg >> 1;
        end
        if (cmd.load_out)
        begin
            mag_reg      <= (energy_reg[20:16] != 5'd0) ? 8'hFF : root_reg;
            last_out_reg <= last_reg;
        end
    end

    assign stat.clear_done = (clear_addr_reg == LAST_ADDR);
    assign stat.has_result = pos_valid;
    assign stat.root_last  = bit_reg[0];
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign magnitude     = mag_reg;
    assign last_of_frame = last_out_reg;
    assign out_valid     = out_valid_reg;

endmodule

>>> design/sobel_edge_magnitude.sv
// a pixel that yields a result passes through the calc, energy, square-root and output
// states before out_valid rises, a border pixel only through calc; one pixel is in flight
// at a time, and the next is taken only when the controller is back in idle
// reset: after rst_n the line store is cleared, one entry a cycle, for all
// MAX_LINE_PIXELS entries (1024 by default) before the first pixel is taken
`include "assert_macros.svh"
module sobel_edge_magnitude
    import sobel_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = DEF_MAX_LINE_PIXELS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic [7:0]  pixel,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [7:0]  magnitude,
    output logic        last_of_frame,
    output logic        out_valid,
    input  logic        out_ready
);

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic                   wr_en;
    ctrl_cmd_t              cmd;
    dp_stat_t               stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[WIDTH_BITS-1:0];
                REG_HEIGHT: height_reg <= pwdata[HEIGHT_BITS-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            default:    prdata = '0;
        endcase
    end

    sobel_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sobel_dp #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .image_width   (width_reg),
        .image_height  (height_reg),
        .pixel         (pixel),
        .magnitude     (magnitude),
        .last_of_frame (last_of_frame),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

    // one item in flight: no accept right after an accept
    `ASSERT_PROP(a_one_in_flight, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
    // a new result is only loaded from the busy side of the controller
    `ASSERT_PROP(a_load_from_busy, clk, rst_n, $rose(out_valid) |-> $past(!in_ready))
    // the controller never issues a store clear and a pixel step together
    `ASSERT_NEVER(a_clear_vs_calc, clk, rst_n, cmd.clear && (cmd.calc || cmd.accept))

endmodule
